/* rtl/core/timme_pkg.sv */
`default_nettype none

package timme_pkg;

    localparam logic [2:0] FUNC_T1_IMM8  = 3'd0;
    localparam logic [2:0] FUNC_T2_MOD   = 3'd1;
    localparam logic [2:0] FUNC_MOVW     = 3'd2;
    localparam logic [2:0] FUNC_MOVT     = 3'd3;
    localparam logic [2:0] FUNC_MOV32    = 3'd4;
    localparam logic [2:0] FUNC_VMOV_F32 = 3'd5;

    localparam logic [3:0] CNT_NONE   = 4'd0;
    localparam logic [3:0] CNT_NARROW = 4'd2;
    localparam logic [3:0] CNT_WIDE   = 4'd4;
    localparam logic [3:0] CNT_PAIR   = 4'd8;

    localparam logic [7:0] T1_MOV_HI   = 8'b0010_0000;
    localparam logic [7:0] T2_MOV_B1   = 8'b1111_0000;
    localparam logic [7:0] T2_MOV_B0   = 8'b0100_0000 | 8'b0000_1111;
    localparam logic [7:0] T2_S_BIT    = 8'b0001_0000;
    localparam logic [7:0] W16_B1      = 8'b1111_0010;
    localparam logic [7:0] MOVW_B0     = 8'b0100_0000;
    localparam logic [7:0] MOVT_B0     = 8'b1100_0000;
    localparam logic [7:0] VMOV_B1     = 8'b1110_1110;
    localparam logic [7:0] VMOV_B0     = 8'b1011_0000;
    localparam logic [7:0] VMOV_B3     = 8'b0000_1010;

endpackage

`default_nettype wire

/* rtl/core/thumb_immediate_move_encoder_unit.sv */
`default_nettype none

// Thumb-2 move-immediate encoder. Each input word selects one of six move
// encodings (MOVS imm8, MOV.W with modified immediate, MOVW, MOVT, a MOVW+MOVT
// pair, VMOV.F32 imm8) and returns the machine code bytes in memory order with
// halfwords little-endian, plus the count of valid bytes (2, 4 or 8; 0 with
// all-zero code for selector codes 6 and 7). One word is taken per cycle; a
// result passes from the input register through the leading-one detector and
// packing logic to the result register. The input stalls only while both
// registers hold words and the result is not taken. Modified immediates whose
// low bits do not fit are truncated.

module thumb_immediate_move_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [4:0]  s_reg_num,
    input  wire logic [31:0] s_imm_value,
    input  wire logic        s_set_flags,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_code,
    output logic [3:0]       m_byte_count
);
    import timme_pkg::*;

    function automatic logic [31:0] wide16(input logic [3:0] rd, input logic [15:0] v,
                                           input logic [7:0] op);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = op | {4'b0, v[15:12]};
        b1 = W16_B1 | {5'b0, v[11], 2'b0};
        b2 = v[7:0];
        b3 = {1'b0, v[10:8], rd};
        return {b3, b2, b1, b0};
    endfunction

    logic        in_valid_reg;
    logic [2:0]  func_reg;
    logic [4:0]  reg_num_reg;
    logic [31:0] imm_reg;
    logic        set_flags_reg;

    logic        m_valid_reg;
    logic [63:0] code_reg;
    logic [3:0]  byte_count_reg;

    logic        advance;
    logic [4:0]  lz;
    logic [31:0] norm;
    logic [11:0] imm12;
    logic [7:0]  vimm8;
    logic [63:0] code_next;
    logic [3:0]  byte_count_next;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    // leading-one detect and normalize
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (imm_reg[i]) begin
                lz = 5'(31 - i);
            end
        end
        norm = imm_reg << lz;
        if (|imm_reg[31:8]) begin
            imm12 = {lz + 5'd8, norm[30:24]};
        end else begin
            imm12 = {4'b0, imm_reg[7:0]};
        end
        vimm8 = {imm_reg[31], ~imm_reg[30], imm_reg[24:19]};
    end

    always_comb begin
        code_next       = '0;
        byte_count_next = CNT_NONE;
        unique case (func_reg)
            FUNC_T1_IMM8: begin
                code_next       = {48'b0, T1_MOV_HI | {5'b0, reg_num_reg[2:0]}, imm_reg[7:0]};
                byte_count_next = CNT_NARROW;
            end
            FUNC_T2_MOD: begin
                code_next = {32'b0,
                             {1'b0, imm12[10:8], reg_num_reg[3:0]},
                             imm12[7:0],
                             T2_MOV_B1 | {5'b0, imm12[11], 2'b0},
                             T2_MOV_B0 | (set_flags_reg ? T2_S_BIT : 8'b0)};
                byte_count_next = CNT_WIDE;
            end
            FUNC_MOVW: begin
                code_next       = {32'b0, wide16(reg_num_reg[3:0], imm_reg[15:0], MOVW_B0)};
                byte_count_next = CNT_WIDE;
            end
            FUNC_MOVT: begin
                code_next       = {32'b0, wide16(reg_num_reg[3:0], imm_reg[15:0], MOVT_B0)};
                byte_count_next = CNT_WIDE;
            end
            FUNC_MOV32: begin
                code_next       = {wide16(reg_num_reg[3:0], imm_reg[31:16], MOVT_B0),
                                   wide16(reg_num_reg[3:0], imm_reg[15:0], MOVW_B0)};
                byte_count_next = CNT_PAIR;
            end
            FUNC_VMOV_F32: begin
                code_next = {32'b0,
                             VMOV_B3 | {reg_num_reg[4:1], 4'b0},
                             {4'b0, vimm8[3:0]},
                             VMOV_B1,
                             VMOV_B0 | {1'b0, reg_num_reg[0], 2'b0, vimm8[7:4]}};
                byte_count_next = CNT_WIDE;
            end
            default: begin
                code_next       = '0;
                byte_count_next = CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg      <= s_func;
            reg_num_reg   <= s_reg_num;
            imm_reg       <= s_imm_value;
            set_flags_reg <= s_set_flags;
        end
        if (advance && in_valid_reg) begin
            code_reg       <= code_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code       = code_reg;
    assign m_byte_count = byte_count_reg;

endmodule

`default_nettype wire

/* rtl/core/timme_checker.sv */
`default_nettype none

module timme_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_code,
    input wire logic [3:0]  m_byte_count
);
    import timme_pkg::*;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code) && $stable(m_byte_count))
        else $error("stalled result changed");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_count == CNT_NONE || m_byte_count == CNT_NARROW ||
                     m_byte_count == CNT_WIDE || m_byte_count == CNT_PAIR))
        else $error("bad byte count");

    // bytes past the count are zero
    a_narrow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_byte_count == CNT_NARROW || m_byte_count == CNT_NONE)
            |-> m_code[63:16] == 48'b0)
        else $error("nonzero bytes beyond halfword");

    a_wide_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_count == CNT_WIDE |-> m_code[63:32] == 32'b0)
        else $error("nonzero bytes beyond word");

endmodule

bind thumb_immediate_move_encoder_unit timme_checker u_timme_checker (.*);

`default_nettype wire
